### rtl/core/leconv_pkg.sv
package leconv_pkg;

    // Stream limits.
    localparam int LINE_LIMIT  = 1024;
    localparam int RECORD_SIZE = 128;

    localparam int LEN_W   = $clog2(LINE_LIMIT);
    localparam int PHASE_W = $clog2(RECORD_SIZE);

    // Line length, counted in stored bytes, at which the too-long error fires; lines stay shorter.
    localparam logic [LEN_W:0]   LEN_MAX = (LEN_W + 1)'(LINE_LIMIT - 1);
    localparam logic [PHASE_W:0] REC_SZ  = (PHASE_W + 1)'(RECORD_SIZE);

    // Character codes.
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SUB      = 8'h1A;
    localparam logic [7:0] BIN_LIMIT   = 8'h07;
    localparam logic [7:0] PARITY_MASK = 8'h7F;

    // Configuration register indexes.
    localparam int         CFG_IDX_W  = 1;
    localparam int         CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP = 1'b1;

    // Request queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        MODE_UNIX  = 3'd0,
        MODE_DOS   = 3'd1,
        MODE_CPM   = 3'd2,
        MODE_MAC   = 3'd3,
        MODE_UNMAC = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BINARY = 2'd1,
        STAT_LONG   = 2'd2
    } status_t;

    // One queued request: the final result, preceded by a CR byte when two is set.
    typedef struct packed {
        logic       two;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       file_done;
        status_t    status;
        logic [7:0] pad_count;
    } entry_t;

    // Queue status seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Advance the record phase by k output bytes, wrapping at the record size.
    function automatic logic [PHASE_W-1:0] phase_add(input logic [PHASE_W-1:0] p,
                                                     input logic [1:0] k);
        logic [PHASE_W:0] s;
        s = {1'b0, p} + (PHASE_W + 1)'(k);
        if (s >= REC_SZ) begin
            s = s - REC_SZ;
        end
        return s[PHASE_W-1:0];
    endfunction

    // SUB fill count that completes the current record.
    function automatic logic [7:0] pad_of(input logic [PHASE_W-1:0] p);
        logic [PHASE_W:0] d;
        d = REC_SZ - {1'b0, p};
        return 8'(d);
    endfunction

endpackage

### rtl/core/leconv_front.sv
module leconv_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [leconv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [leconv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [7:0]                        s_in_byte,
    input  leconv_pkg::qstat_t                q_stat,
    output logic                              q_push,
    output leconv_pkg::entry_t                q_entry
);
    import leconv_pkg::*;

    logic [2:0]         mode_reg;
    logic               strip_reg;
    logic               held_cr_reg, held_cr_next;
    logic [LEN_W-1:0]   line_len_reg, line_len_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               finished_reg, finished_next;

    mode_t              eff_mode;
    logic               accept;
    logic               is_bad;
    logic [7:0]         c_eff;
    logic [7:0]         c_conv;
    logic [LEN_W:0]     len_inc;
    logic [PHASE_W-1:0] phase_cr;
    entry_t             ok_entry;
    entry_t             err_entry;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 3'd0;
            strip_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data;
                CFG_STRIP: strip_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Per-file state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cr_reg  <= 1'b0;
            line_len_reg <= '0;
            phase_reg    <= '0;
            finished_reg <= 1'b0;
        end else begin
            held_cr_reg  <= held_cr_next;
            line_len_reg <= line_len_next;
            phase_reg    <= phase_next;
            finished_reg <= finished_next;
        end
    end

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // Unused mode codes behave as unix.
    assign eff_mode = (mode_reg > MODE_UNMAC) ? MODE_UNIX : mode_t'(mode_reg);

    // Byte classification and conversion.
    assign is_bad   = (s_in_byte < BIN_LIMIT) || s_in_byte[7];
    assign c_eff    = is_bad ? (s_in_byte & PARITY_MASK) : s_in_byte;
    assign c_conv   = (c_eff == CH_CR && eff_mode == MODE_UNMAC) ? CH_LF : c_eff;
    assign len_inc  = {1'b0, line_len_reg} + (LEN_W + 1)'(1);
    assign phase_cr = phase_add(phase_reg, {1'b0, held_cr_reg});

    // Closing result of a good file: a held CR goes out first.
    always_comb begin
        ok_entry            = '0;
        ok_entry.two        = held_cr_reg;
        ok_entry.file_done  = 1'b1;
        ok_entry.status     = STAT_OK;
        ok_entry.pad_count  = (eff_mode == MODE_CPM) ? pad_of(phase_cr) : 8'd0;
        err_entry           = '0;
        err_entry.file_done = 1'b1;
        err_entry.status    = STAT_BINARY;
    end

    // Classify the request and update the file state.
    always_comb begin
        held_cr_next  = held_cr_reg;
        line_len_next = line_len_reg;
        phase_next    = phase_reg;
        finished_next = finished_reg;
        q_push        = 1'b0;
        q_entry       = '0;

        if (accept) begin
            if (finished_reg) begin
                // Skipping the rest of a closed file until its end.
                if (s_op) begin
                    finished_next = 1'b0;
                end
            end else if (s_op || (!is_bad && s_in_byte == CH_SUB) ||
                         (is_bad && strip_reg && c_eff == CH_SUB)) begin
                q_push        = 1'b1;
                q_entry       = ok_entry;
                held_cr_next  = 1'b0;
                line_len_next = '0;
                phase_next    = '0;
                finished_next = !s_op;
            end else if (s_in_byte == CH_NUL) begin
                // NUL bytes vanish.
            end else if (is_bad && !strip_reg) begin
                q_push        = 1'b1;
                q_entry       = err_entry;
                held_cr_next  = 1'b0;
                line_len_next = '0;
                phase_next    = '0;
                finished_next = 1'b1;
            end else if (c_eff < BIN_LIMIT) begin
                // Stripped byte that falls into the control range is dropped.
            end else if (c_conv == CH_LF) begin
                q_push           = 1'b1;
                q_entry.byte_valid = 1'b1;
                q_entry.status   = STAT_OK;
                held_cr_next     = 1'b0;
                line_len_next    = '0;
                case (eff_mode)
                    MODE_DOS, MODE_CPM: begin
                        q_entry.two      = 1'b1;
                        q_entry.out_byte = CH_LF;
                        phase_next       = phase_add(phase_reg, 2'd2);
                    end
                    MODE_MAC: begin
                        q_entry.out_byte = CH_CR;
                        phase_next       = phase_add(phase_reg, 2'd1);
                    end
                    default: begin
                        q_entry.out_byte = CH_LF;
                        phase_next       = phase_add(phase_reg, 2'd1);
                    end
                endcase
            end else if (len_inc >= LEN_MAX) begin
                q_push           = 1'b1;
                q_entry          = err_entry;
                q_entry.status   = STAT_LONG;
                held_cr_next     = 1'b0;
                line_len_next    = '0;
                phase_next       = '0;
                finished_next    = 1'b1;
            end else begin
                line_len_next = len_inc[LEN_W-1:0];
                if (c_conv == CH_CR) begin
                    // A new CR is held; an older one goes out.
                    held_cr_next = 1'b1;
                    if (held_cr_reg) begin
                        q_push             = 1'b1;
                        q_entry.out_byte   = CH_CR;
                        q_entry.byte_valid = 1'b1;
                        phase_next         = phase_add(phase_reg, 2'd1);
                    end
                end else begin
                    held_cr_next       = 1'b0;
                    q_push             = 1'b1;
                    q_entry.two        = held_cr_reg;
                    q_entry.out_byte   = c_conv;
                    q_entry.byte_valid = 1'b1;
                    phase_next         = phase_add(phase_reg, {held_cr_reg, !held_cr_reg});
                end
            end
        end
    end

    // A request never leaves the front while the skip flag is set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && finished_reg) |-> !q_push)
        else $error("front pushed a request while skipping a closed file");

    // A closed file leaves the per-file counters at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_entry.file_done) |=> (line_len_reg == '0 && phase_reg == '0 &&
                                           !held_cr_reg))
        else $error("file state not cleared after a closing result");

    // The line counter stays below the too-long threshold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, line_len_reg} < LEN_MAX))
        else $error("line length counter passed its limit");

endmodule

### rtl/core/leconv_queue.sv
module leconv_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  leconv_pkg::entry_t push_entry,
    input  logic               pop,
    output leconv_pkg::entry_t head,
    output leconv_pkg::qstat_t stat
);
    import leconv_pkg::*;

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign stat.full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && stat.full))
        else $error("request pushed into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && stat.empty))
        else $error("request popped from an empty queue");

endmodule

### rtl/core/leconv_back.sv
module leconv_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  leconv_pkg::entry_t head,
    input  leconv_pkg::qstat_t q_stat,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_byte_valid,
    output logic               m_file_done,
    output logic [1:0]         m_status,
    output logic [7:0]         m_pad_count,
    output logic               m_last
);
    import leconv_pkg::*;

    logic       m_valid_reg, m_valid_next;
    logic       second_reg, second_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       byte_valid_reg, byte_valid_next;
    logic       file_done_reg, file_done_next;
    status_t    status_reg, status_next;
    logic [7:0] pad_reg, pad_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !m_valid_reg || m_ready;

    // Fill the output register from the queue head, one result a cycle while the receiver takes them.
    always_comb begin
        m_valid_next    = m_valid_reg;
        second_next     = second_reg;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        file_done_next  = file_done_reg;
        status_next     = status_reg;
        pad_next        = pad_reg;
        last_next       = last_reg;
        q_pop           = 1'b0;
        if (load) begin
            m_valid_next = !q_stat.empty;
            if (!q_stat.empty) begin
                if (head.two && !second_reg) begin
                    // Leading CR of a two-result request.
                    second_next     = 1'b1;
                    out_byte_next   = CH_CR;
                    byte_valid_next = 1'b1;
                    file_done_next  = 1'b0;
                    status_next     = STAT_OK;
                    pad_next        = 8'd0;
                    last_next       = 1'b0;
                end else begin
                    second_next     = 1'b0;
                    q_pop           = 1'b1;
                    out_byte_next   = head.out_byte;
                    byte_valid_next = head.byte_valid;
                    file_done_next  = head.file_done;
                    status_next     = head.status;
                    pad_next        = head.pad_count;
                    last_next       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            second_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            second_reg  <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        file_done_reg  <= file_done_next;
        status_reg     <= status_next;
        pad_reg        <= pad_next;
        last_reg       <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_byte_valid = byte_valid_reg;
    assign m_file_done  = file_done_reg;
    assign m_status     = status_reg;
    assign m_pad_count  = pad_reg;
    assign m_last       = last_reg;

    // While the second half of a request is pending, its entry is still queued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> !q_stat.empty)
        else $error("second result pending with an empty queue");

    // Only the leading CR of a request goes out without last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_byte_valid && m_out_byte == CH_CR && !m_file_done))
        else $error("non-final result is not a CR byte");

    // A closing result never carries a byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_file_done) |-> (!m_byte_valid && m_last))
        else $error("closing result carries a byte");

endmodule

### rtl/core/line_ending_converter_top.sv
// Line-end converter for a byte stream.
// Input channel (s_*): one request per byte, s_op high marks end of file.
// Output channel (m_*): byte results and one closing result per file, with
// status and, in cpm mode, the SUB fill count; m_last ends each request's results.
// The user must write configuration (cfg_we, cfg_index, cfg_data) between files,
// not enforced by the block; index 0 sets the mode, index 1 the parity strip.
// A request's results are registered first in a queue entry, then in the
// output register. The output stage gives one result per cycle while the
// receiver takes them, so a request that yields two results (CR then another
// byte) occupies it for both; requests yielding none push nothing to the queue.
// The front classifies one request per cycle, while the queue is not full, into
// a two-entry queue; the back drains it into a single output register.
// When the receiver stalls the output holds, the queue fills, and s_ready
// drops once both queue entries are taken.
// Reset clears the mode to unix, strip off, the per-file state, the queue and
// the output valid; there is no clearing pass.
module line_ending_converter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [leconv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [leconv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [7:0]                        s_in_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_out_byte,
    output logic                              m_byte_valid,
    output logic                              m_file_done,
    output logic [1:0]                        m_status,
    output logic [7:0]                        m_pad_count,
    output logic                              m_last
);
    import leconv_pkg::*;

    qstat_t q_stat;
    logic   q_push;
    logic   q_pop;
    entry_t q_entry;
    entry_t q_head;

    leconv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_in_byte (s_in_byte),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    leconv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    leconv_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (q_head),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_file_done  (m_file_done),
        .m_status     (m_status),
        .m_pad_count  (m_pad_count),
        .m_last       (m_last)
    );

endmodule
